>>> sv/wsi_pkg.sv
// ----------------------------------------------------------------------------
// wsi_pkg
// Shared types and constants of the wide string to integer parser.
// ----------------------------------------------------------------------------
`default_nettype none

package wsi_pkg;

  localparam int CHAR_W    = 16;
  localparam int RADIX_W   = 6;
  localparam int VALUE_W   = 32;
  localparam int OFF_W     = 16;
  localparam int ACC_W     = 33;
  localparam int DVAL_W    = 6;
  localparam int POS_W_DEF = 16;

  // Queue depth between the classifier and the executor; a power of two.
  localparam int QDEPTH = 2;

  localparam logic [ACC_W-1:0] ACC_CAP = 33'h1_0000_0000;
  localparam logic [ACC_W-1:0] POS_LIMIT = 33'h0_7FFF_FFFF;
  localparam logic [ACC_W-1:0] NEG_LIMIT = 33'h0_8000_0000;

  localparam logic [VALUE_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] SAT_NEG = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] SAT_U   = 32'hFFFF_FFFF;

  // Configuration register indexes.
  localparam logic CFG_SIGNED_MODE = 1'b0;
  localparam logic CFG_ZERO_ANY    = 1'b1;

  localparam logic [CHAR_W-1:0] CH_NUL   = 16'h0000;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 16'h002B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 16'h002D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 16'h0030;
  localparam logic [CHAR_W-1:0] CH_UA    = 16'h0041;
  localparam logic [CHAR_W-1:0] CH_UX    = 16'h0058;
  localparam logic [CHAR_W-1:0] CH_UZ    = 16'h005A;
  localparam logic [CHAR_W-1:0] CH_LA    = 16'h0061;
  localparam logic [CHAR_W-1:0] CH_LX    = 16'h0078;
  localparam logic [CHAR_W-1:0] CH_LZ    = 16'h007A;

  localparam int NBLK = 18;
  localparam int NWS  = 26;

  localparam logic [CHAR_W-1:0] BLK_ZERO [NBLK] = '{
    16'h0030, 16'h0660, 16'h06F0, 16'h0966, 16'h09E6, 16'h0A66, 16'h0AE6,
    16'h0B66, 16'h0C66, 16'h0CE6, 16'h0D66, 16'h0E50, 16'h0ED0, 16'h0F20,
    16'h1040, 16'h17E0, 16'h1810, 16'hFF10
  };

  localparam logic [CHAR_W-1:0] WS_UNITS [NWS] = '{
    16'h0009, 16'h000A, 16'h000B, 16'h000C, 16'h000D, 16'h0020, 16'h0085,
    16'h00A0, 16'h1680, 16'h180E, 16'h2000, 16'h2001, 16'h2002, 16'h2003,
    16'h2004, 16'h2005, 16'h2006, 16'h2007, 16'h2008, 16'h2009, 16'h200A,
    16'h2028, 16'h2029, 16'h202F, 16'h205F, 16'h3000
  };

  // One classified character as it travels from the front to the back.
  typedef struct packed {
    logic               nul;
    logic               space;
    logic               minus;
    logic               plus;
    logic               xchar;
    logic               zero;
    logic               dig_ok;
    logic [DVAL_W-1:0]  dig_val;
    logic [RADIX_W-1:0] radix;
  } item_t;

endpackage

`default_nettype wire

>>> sv/wide_string_to_integer_parser.sv
// ----------------------------------------------------------------------------
// wide_string_to_integer_parser
// Streaming parser that turns a NUL terminated UTF-16 string into a 32-bit
// integer, with an end offset and a range error flag.
//
//  Channel  Direction  Handshake            Payload
//  in       input      in_valid / in_stall  wide_char, radix
//  out      output     out_valid/out_stall  value, end_offset, range_error
//  cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One character is taken per cycle while in_stall is low; the classifier and
// the executor each handle one character a cycle unless a terminator meets a
// stalled output, the multiply-add on the accumulator being the longest path.
// A result is registered once the output register is free or draining.
// in_stall rises only when the two-entry queue is full, which happens when
// the output side stalls on a pending result. Reset clears the queue and the
// parse state and returns the configuration registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module wide_string_to_integer_parser
  import wsi_pkg::*;
#(
  parameter int POSITION_WIDTH = POS_W_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [CHAR_W-1:0]  wide_char,
  input  wire logic [RADIX_W-1:0] radix,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [VALUE_W-1:0]      value,
  output logic [OFF_W-1:0]        end_offset,
  output logic                    range_error,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic               cfg_data
);

  logic  signed_mode;
  logic  zero_any_block;
  logic  push;
  logic  q_full;
  logic  q_valid;
  logic  pop;
  item_t push_item;
  item_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode    <= 1'b1;
      zero_any_block <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SIGNED_MODE: signed_mode    <= cfg_data;
        CFG_ZERO_ANY:    zero_any_block <= cfg_data;
        default:         signed_mode    <= signed_mode;
      endcase
    end
  end

  wsi_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .wide_char      (wide_char),
    .radix          (radix),
    .zero_any_block (zero_any_block),
    .q_full         (q_full),
    .push           (push),
    .item           (push_item)
  );

  wsi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  wsi_back #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .pop         (pop),
    .signed_mode (signed_mode),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .value       (value),
    .end_offset  (end_offset),
    .range_error (range_error)
  );

endmodule

`default_nettype wire

>>> sv/wsi_front.sv
// ----------------------------------------------------------------------------
// wsi_front
// Accepts characters and classifies them: terminator, whitespace, sign, prefix
// letter, leading zero and digit value.
// ----------------------------------------------------------------------------
`default_nettype none

module wsi_front
  import wsi_pkg::*;
(
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [CHAR_W-1:0]  wide_char,
  input  wire logic [RADIX_W-1:0] radix,
  input  wire logic               zero_any_block,
  input  wire logic               q_full,
  output logic                    push,
  output item_t                   item
);

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    logic              blk_hit;
    logic [3:0]        blk_val;
    logic [CHAR_W-1:0] diff;
    logic              ws_hit;
    blk_hit = 1'b0;
    blk_val = 4'd0;
    ws_hit  = 1'b0;
    for (int i = 0; i < NBLK; i++) begin
      diff = wide_char - BLK_ZERO[i];
      if (!blk_hit && diff <= CHAR_W'(9)) begin
        blk_hit = 1'b1;
        blk_val = diff[3:0];
      end
    end
    for (int i = 0; i < NWS; i++) begin
      if (wide_char == WS_UNITS[i]) ws_hit = 1'b1;
    end

    item.nul   = (wide_char == CH_NUL);
    item.space = ws_hit;
    item.minus = (wide_char == CH_MINUS);
    item.plus  = (wide_char == CH_PLUS);
    item.xchar = (wide_char == CH_LX) || (wide_char == CH_UX);
    item.zero  = zero_any_block ? (blk_hit && (blk_val == 4'd0)) : (wide_char == CH_ZERO);
    item.radix = radix;

    if (blk_hit) begin
      item.dig_ok  = 1'b1;
      item.dig_val = DVAL_W'(blk_val);
    end else if (wide_char >= CH_LA && wide_char <= CH_LZ) begin
      item.dig_ok  = 1'b1;
      item.dig_val = DVAL_W'(wide_char - CH_LA) + DVAL_W'(10);
    end else if (wide_char >= CH_UA && wide_char <= CH_UZ) begin
      item.dig_ok  = 1'b1;
      item.dig_val = DVAL_W'(wide_char - CH_UA) + DVAL_W'(10);
    end else begin
      item.dig_ok  = 1'b0;
      item.dig_val = '0;
    end
  end

endmodule

`default_nettype wire

>>> sv/wsi_queue.sv
// ----------------------------------------------------------------------------
// wsi_queue
// Short queue of classified characters between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module wsi_queue
  import wsi_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  output logic       q_valid,
  output item_t      q_item,
  input  wire logic  pop
);

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  item_t          mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full    = (count == (QAW+1)'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QDEPTH) && !(push && full) && !(pop && !q_valid))
    else $error("queue pushed while full or popped while empty");

endmodule

`default_nettype wire

>>> sv/wsi_back.sv
// ----------------------------------------------------------------------------
// wsi_back
// Executes classified characters: sign and base resolution, digit
// accumulation with saturation, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wsi_back
  import wsi_pkg::*;
#(
  parameter int POSITION_WIDTH = POS_W_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  input  wire item_t               q_item,
  output logic                     pop,
  input  wire logic                signed_mode,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [VALUE_W-1:0]       value,
  output logic [OFF_W-1:0]         end_offset,
  output logic                     range_error
);

  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_BODY   = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_DIGITS = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  localparam int PROD_W = ACC_W + RADIX_W + 1;

  logic [2:0]                phase, phase_next;
  logic                      negative, negative_next;
  logic [RADIX_W-1:0]        active_base, active_base_next;
  logic [ACC_W-1:0]          acc, acc_next;
  logic [POSITION_WIDTH-1:0] position, position_next;
  logic [POSITION_WIDTH-1:0] last_end, last_end_next;

  logic [RADIX_W-1:0]        base_cur;
  logic [RADIX_W-1:0]        take_base;
  logic [POSITION_WIDTH-1:0] pos_step;
  logic [PROD_W-1:0]         mac;
  logic [ACC_W-1:0]          acc_sat;
  logic                      take_ok;

  logic [VALUE_W-1:0]        res_value;
  logic [OFF_W-1:0]          res_offset;
  logic                      res_error;

  // A result can only leave when the output register is free or draining.
  assign pop = q_valid && (!q_item.nul || !out_valid || !out_stall);

  // The base is latched from the first character of each string.
  assign base_cur = (phase == PH_LEAD && position == '0) ? q_item.radix : active_base;
  assign pos_step = (position == '1) ? position : position + 1'b1;

  always_comb begin
    unique case (phase)
      PH_ZERO:   take_base = (base_cur == '0) ? RADIX_W'(8) : base_cur;
      PH_DIGITS: take_base = base_cur;
      default:   take_base = (base_cur == '0) ? RADIX_W'(10) : base_cur;
    endcase
  end

  assign take_ok = q_item.dig_ok && (q_item.dig_val < take_base);
  assign mac     = PROD_W'(acc) * PROD_W'(take_base) + PROD_W'(q_item.dig_val);
  assign acc_sat = (mac > PROD_W'(ACC_CAP)) ? ACC_CAP : mac[ACC_W-1:0];

  always_comb begin
    logic first;
    logic take;
    first            = 1'b0;
    take             = 1'b0;
    phase_next       = phase;
    negative_next    = negative;
    active_base_next = base_cur;
    acc_next         = acc;
    last_end_next    = last_end;
    position_next    = pos_step;

    unique case (phase)
      PH_LEAD: begin
        if (q_item.space) begin
          phase_next = PH_LEAD;
        end else if (q_item.minus) begin
          negative_next = 1'b1;
          phase_next    = PH_BODY;
        end else if (q_item.plus) begin
          phase_next = PH_BODY;
        end else begin
          first = 1'b1;
        end
      end
      PH_BODY: first = 1'b1;
      PH_ZERO: begin
        if (q_item.xchar) begin
          active_base_next = RADIX_W'(16);
          acc_next         = '0;
          last_end_next    = '0;
          phase_next       = PH_DIGITS;
        end else begin
          active_base_next = take_base;
          take             = 1'b1;
        end
      end
      PH_DIGITS: take = 1'b1;
      default:   phase_next = phase;
    endcase

    if (first) begin
      if ((base_cur == '0 || base_cur == RADIX_W'(16)) && q_item.zero) begin
        acc_next      = '0;
        last_end_next = pos_step;
        phase_next    = PH_ZERO;
      end else begin
        active_base_next = take_base;
        take             = 1'b1;
      end
    end

    if (take) begin
      if (take_ok) begin
        acc_next      = acc_sat;
        last_end_next = pos_step;
        phase_next    = PH_DIGITS;
      end else begin
        phase_next = PH_DONE;
      end
    end

    if (q_item.nul) begin
      phase_next       = PH_LEAD;
      negative_next    = 1'b0;
      active_base_next = '0;
      acc_next         = '0;
      position_next    = '0;
      last_end_next    = '0;
    end
  end

  // The terminator adds no digit to the accumulator, so the result is formed
  // from the current state.
  generate
    if (POSITION_WIDTH > OFF_W) begin : g_off_sat
      assign res_offset = (|last_end[POSITION_WIDTH-1:OFF_W]) ? '1 : last_end[OFF_W-1:0];
    end else begin : g_off_ext
      assign res_offset = OFF_W'(last_end);
    end
  endgenerate

  always_comb begin
    logic [VALUE_W-1:0] mag;
    mag = acc[VALUE_W-1:0];
    if (last_end == '0) begin
      res_value = '0;
      res_error = 1'b0;
    end else if (signed_mode && negative && acc > NEG_LIMIT) begin
      res_value = SAT_NEG;
      res_error = 1'b1;
    end else if (signed_mode && !negative && acc > POS_LIMIT) begin
      res_value = SAT_POS;
      res_error = 1'b1;
    end else if (!signed_mode && acc[ACC_W-1]) begin
      res_value = SAT_U;
      res_error = 1'b1;
    end else begin
      res_value = negative ? (VALUE_W'(0) - mag) : mag;
      res_error = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LEAD;
      negative    <= 1'b0;
      active_base <= '0;
      acc         <= '0;
      position    <= '0;
      last_end    <= '0;
    end else if (pop) begin
      phase       <= phase_next;
      negative    <= negative_next;
      active_base <= active_base_next;
      acc         <= acc_next;
      position    <= position_next;
      last_end    <= last_end_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && q_item.nul) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_item.nul) begin
      value       <= res_value;
      end_offset  <= (last_end == '0) ? '0 : res_offset;
      range_error <= res_error;
    end
  end

  a_acc_capped: assert property (@(posedge clk) disable iff (rst)
    acc <= ACC_CAP)
    else $error("accumulator above its saturation cap");

  a_nul_clears: assert property (@(posedge clk) disable iff (rst)
    pop && q_item.nul |=> phase == PH_LEAD && position == '0 && acc == '0)
    else $error("state not cleared after a terminator");

  a_sat_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |->
      value == SAT_POS || value == SAT_NEG || value == SAT_U)
    else $error("range error without a saturated value");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_offset == '0 |-> value == '0 && !range_error)
    else $error("nonzero result with nothing converted");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> !pop || !$past(q_item.nul) || $stable(value))
    else $error("stalled result overwritten");

endmodule

`default_nettype wire
